// File: rtl/mgd_pkg.sv
package mgd_pkg;

  // Dimensions in use, limited to the three axes that the ports carry.
  localparam int NUM_DIMS         = 3;
  localparam int MAX_BINS_PER_DIM = 16;
  localparam int NUM_AXES         = 3;
  localparam int ACT_DIMS         = (NUM_DIMS < 1) ? 1 :
                                    ((NUM_DIMS > NUM_AXES) ? NUM_AXES : NUM_DIMS);

  localparam int HIST_DEPTH = 4096;
  localparam int ADDR_W     = 12;
  localparam int BIN_W      = 32;
  localparam int LEN_W      = 5;
  localparam int NEAR_W     = 4;
  localparam int COORD_W    = NEAR_W + 2;
  localparam int POS_W      = 21;
  localparam int FRAC_W     = 16;
  localparam int FAC_W      = 17;
  localparam int PROD_W     = 2 * FAC_W;
  localparam int STRIDE_W   = 9;
  localparam int FLAT_W     = 14;
  localparam int CORNER_W   = 3;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  localparam logic [FAC_W-1:0] UNIT_WEIGHT = 17'h10000;

  // Operation codes on the input port. The spare code behaves as a plain read.
  localparam logic [OP_W-1:0] OPC_DEPOSIT   = 2'd0;
  localparam logic [OP_W-1:0] OPC_READ      = 2'd1;
  localparam logic [OP_W-1:0] OPC_READ_ZERO = 2'd2;
  localparam logic [OP_W-1:0] OPC_SPARE     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_Z = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_DEPOSIT,
    CMD_READ,
    CMD_READ_ZERO
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_READ_DATA,
    ST_DEPOSIT,
    ST_DRAIN
  } back_state_t;

  // Classified item as it travels from the front end to the back end.
  typedef struct packed {
    cmd_kind_t                            kind;
    logic                                 skipped;
    logic [ADDR_W-1:0]                    addr;
    logic [NUM_AXES-1:0]                  split;
    logic [NUM_AXES-1:0]                  neg;
    logic [NUM_AXES-1:0][FAC_W-1:0]       fac;
    logic [NUM_AXES-1:0][NEAR_W-1:0]      near;
    logic [NUM_AXES-1:0][LEN_W-1:0]       len;
    logic [STRIDE_W-1:0]                  stride_x;
    logic [LEN_W-1:0]                     stride_y;
  } cmd_t;

  // One corner in flight through the weight and update pipeline.
  typedef struct packed {
    logic                  valid;
    logic                  keep;
    logic [ADDR_W-1:0]     flat;
    logic [NUM_AXES-1:0]   side;
    logic [FAC_W-1:0]      w;
    logic [FAC_W-1:0]      far;
  } corner_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(MAX_BINS_PER_DIM)) r = LEN_W'(MAX_BINS_PER_DIM);
    return r;
  endfunction

endpackage

// File: rtl/multilinear_grid_deposit.sv
// Cloud-in-cell deposition onto a histogram of up to three dimensions. An item
// is taken when start is high and busy is low; each item gives exactly one
// result, shown for a single cycle with done high, and the receiver cannot
// stall it, so results must be captured when they appear. After reset the
// block sweeps its 4096-entry histogram memory to zero, one entry a cycle,
// and holds busy high throughout the sweep. A read reads its bin once it
// leaves the queue and then registers the result; a deposit issues its
// eight corners one per cycle into the read-add-write pipeline of the single
// histogram memory, waits for the pipeline to drain and then registers the
// result. A two-entry queue between the classifying front end and the
// executing back end lets up to two further items be accepted while one is
// being worked on.
module multilinear_grid_deposit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mgd_pkg::OP_W-1:0]    operation,
  input  logic [mgd_pkg::POS_W-1:0]   pos_x,
  input  logic [mgd_pkg::POS_W-1:0]   pos_y,
  input  logic [mgd_pkg::POS_W-1:0]   pos_z,
  input  logic [mgd_pkg::NEAR_W-1:0]  near_x,
  input  logic [mgd_pkg::NEAR_W-1:0]  near_y,
  input  logic [mgd_pkg::NEAR_W-1:0]  near_z,
  input  logic [mgd_pkg::FRAC_W-1:0]  frac_x,
  input  logic [mgd_pkg::FRAC_W-1:0]  frac_y,
  input  logic [mgd_pkg::FRAC_W-1:0]  frac_z,
  input  logic [mgd_pkg::ADDR_W-1:0]  bin_address,
  input  logic                        cfg_we,
  input  logic [mgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mgd_pkg::LEN_W-1:0]   cfg_data,
  output logic                        done,
  output logic [mgd_pkg::BIN_W-1:0]   bin_value,
  output logic                        skipped,
  output logic                        saturated
);

  // Grid lengths, one register per axis. Out-of-range values are clamped
  // in the front end rather than at write time.
  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::LEN_W-1:0] dim_len;

  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::POS_W-1:0]  pos_v;
  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::NEAR_W-1:0] near_v;
  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::FRAC_W-1:0] frac_v;

  mgd_pkg::cmd_t front_cmd, head_cmd;
  logic          accept, q_empty, q_full, pop, clearing;

  assign pos_v  = {pos_z, pos_y, pos_x};
  assign near_v = {near_z, near_y, near_x};
  assign frac_v = {frac_z, frac_y, frac_x};

  // The queue is written in the same cycle as the item is accepted.
  assign busy   = clearing || q_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_len <= {mgd_pkg::NUM_AXES{mgd_pkg::LEN_RESET}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgd_pkg::CFG_LEN_X: dim_len[0] <= cfg_data;
        mgd_pkg::CFG_LEN_Y: dim_len[1] <= cfg_data;
        mgd_pkg::CFG_LEN_Z: dim_len[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: decodes the operation, checks the point against the grid and
  // works out the split factors and strides.
  mgd_front u_front (
    .operation   (operation),
    .pos         (pos_v),
    .near        (near_v),
    .frac        (frac_v),
    .bin_address (bin_address),
    .dim_len     (dim_len),
    .cmd         (front_cmd)
  );

  mgd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end: owns the histogram memory, runs the clearing sweep, the reads
  // and the corner-by-corner deposit pipeline, and registers the result.
  mgd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (!q_empty),
    .head      (head_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .done      (done),
    .bin_value (bin_value),
    .skipped   (skipped),
    .saturated (saturated)
  );

endmodule

// File: rtl/mgd_ram.sv
module mgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/mgd_front.sv
module mgd_front (
  input  logic [mgd_pkg::OP_W-1:0]                                operation,
  input  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::POS_W-1:0]        pos,
  input  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::NEAR_W-1:0]       near,
  input  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::FRAC_W-1:0]       frac,
  input  logic [mgd_pkg::ADDR_W-1:0]                              bin_address,
  input  logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::LEN_W-1:0]        dim_len,
  output mgd_pkg::cmd_t                                           cmd
);

  always_comb begin
    logic [mgd_pkg::LEN_W-1:0] len_e;
    logic [mgd_pkg::POS_W-1:0] lim;
    logic [mgd_pkg::FAC_W-1:0] mag;
    logic                      outside;
    cmd     = '0;
    outside = 1'b0;
    len_e   = '0;
    lim     = '0;
    mag     = '0;
    unique case (operation)
      mgd_pkg::OPC_DEPOSIT:   cmd.kind = mgd_pkg::CMD_DEPOSIT;
      mgd_pkg::OPC_READ_ZERO: cmd.kind = mgd_pkg::CMD_READ_ZERO;
      default:                cmd.kind = mgd_pkg::CMD_READ;
    endcase
    cmd.addr = bin_address;
    for (int d = 0; d < mgd_pkg::NUM_AXES; d++) begin
      if (d < mgd_pkg::ACT_DIMS) begin
        len_e = mgd_pkg::clamp_len(dim_len[d]);
        lim   = mgd_pkg::POS_W'({len_e - mgd_pkg::LEN_W'(1), 8'h00});
        if (pos[d][mgd_pkg::POS_W-1] || ($signed(pos[d]) > $signed(lim))) outside = 1'b1;
        mag = frac[d][mgd_pkg::FRAC_W-1] ?
              mgd_pkg::FAC_W'(-$signed({frac[d][mgd_pkg::FRAC_W-1], frac[d]})) :
              mgd_pkg::FAC_W'(frac[d]);
        cmd.fac[d]   = {mag[mgd_pkg::FAC_W-2:0], 1'b0};
        cmd.split[d] = |frac[d];
        cmd.neg[d]   = frac[d][mgd_pkg::FRAC_W-1];
        cmd.near[d]  = near[d];
        cmd.len[d]   = len_e;
      end else begin
        // An unused axis behaves as a single bin that never splits.
        cmd.len[d] = mgd_pkg::LEN_W'(1);
      end
    end
    cmd.stride_y = cmd.len[2];
    cmd.stride_x = {{(mgd_pkg::STRIDE_W-mgd_pkg::LEN_W){1'b0}}, cmd.len[1]} *
                   {{(mgd_pkg::STRIDE_W-mgd_pkg::LEN_W){1'b0}}, cmd.len[2]};
    cmd.skipped  = (cmd.kind == mgd_pkg::CMD_DEPOSIT) && outside;
  end

endmodule

// File: rtl/mgd_queue.sv
module mgd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mgd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output mgd_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  mgd_pkg::cmd_t                    entries [mgd_pkg::QUEUE_DEPTH];
  logic [mgd_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [mgd_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [mgd_pkg::QUEUE_CNT_W-1:0]  count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == mgd_pkg::QUEUE_CNT_W'(mgd_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + mgd_pkg::QUEUE_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + mgd_pkg::QUEUE_PTR_W'(1);
      count <= count + mgd_pkg::QUEUE_CNT_W'(push) - mgd_pkg::QUEUE_CNT_W'(pop);
    end
  end

endmodule

// File: rtl/mgd_back.sv
module mgd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_avail,
  input  mgd_pkg::cmd_t             head,
  output logic                      pop,
  output logic                      clearing,
  output logic                      done,
  output logic [mgd_pkg::BIN_W-1:0] bin_value,
  output logic                      skipped,
  output logic                      saturated
);

  mgd_pkg::back_state_t            state, state_next;
  mgd_pkg::cmd_t                   cur;
  logic [mgd_pkg::CORNER_W-1:0]    cnt;
  logic [mgd_pkg::ADDR_W-1:0]      clr_cnt;
  logic                            sat_acc;
  mgd_pkg::corner_t                s1, s2, s3;
  mgd_pkg::corner_t                s1_next, s2_next, s3_next;

  logic                            we, re;
  logic [mgd_pkg::ADDR_W-1:0]      waddr, raddr;
  logic [mgd_pkg::BIN_W-1:0]       wdata, rdata;

  logic                            res_valid, res_skip, res_sat;
  logic [mgd_pkg::BIN_W-1:0]       res_value;
  logic                            sat_hit;

  mgd_ram #(.WIDTH(mgd_pkg::BIN_W), .DEPTH(mgd_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing = (state == mgd_pkg::ST_CLEAR);

  // Corner issue stage: coordinates, flat index and first-axis weight.
  always_comb begin
    logic [mgd_pkg::NUM_AXES-1:0][mgd_pkg::COORD_W-1:0] coord;
    logic [mgd_pkg::FLAT_W-1:0]                         flat_sum;
    logic [mgd_pkg::FAC_W-1:0]                          wx;
    logic [mgd_pkg::PROD_W-1:0]                         prod;
    logic                                               keep;
    keep = 1'b1;
    for (int d = 0; d < mgd_pkg::NUM_AXES; d++) begin
      coord[d] = {2'b00, cur.near[d]} +
                 (cnt[d] ? (cur.neg[d] ? {mgd_pkg::COORD_W{1'b1}} : mgd_pkg::COORD_W'(1))
                         : '0);
      if (cnt[d] && !cur.split[d]) keep = 1'b0;
      if (coord[d][mgd_pkg::COORD_W-1] || (coord[d] >= {1'b0, cur.len[d]})) keep = 1'b0;
    end
    flat_sum = mgd_pkg::FLAT_W'(coord[0][mgd_pkg::NEAR_W-1:0]) * mgd_pkg::FLAT_W'(cur.stride_x)
             + mgd_pkg::FLAT_W'(coord[1][mgd_pkg::NEAR_W-1:0]) * mgd_pkg::FLAT_W'(cur.stride_y)
             + mgd_pkg::FLAT_W'(coord[2][mgd_pkg::NEAR_W-1:0]);
    if (flat_sum >= mgd_pkg::FLAT_W'(mgd_pkg::HIST_DEPTH)) keep = 1'b0;
    // With no split the factor is zero, so the near side keeps the whole weight.
    wx   = cnt[0] ? cur.fac[0] : mgd_pkg::UNIT_WEIGHT - cur.fac[0];
    prod = mgd_pkg::PROD_W'(wx) * mgd_pkg::PROD_W'(cur.fac[1]);
    s1_next.valid = (state == mgd_pkg::ST_DEPOSIT);
    s1_next.keep  = keep;
    s1_next.flat  = flat_sum[mgd_pkg::ADDR_W-1:0];
    s1_next.side  = cnt;
    s1_next.w     = wx;
    s1_next.far   = prod[16 +: mgd_pkg::FAC_W];
  end

  // Weights of the second and third axes, with one multiplier, then the bin read.
  always_comb begin
    logic [mgd_pkg::FAC_W-1:0]  wy, wz;
    logic [mgd_pkg::PROD_W-1:0] prod;
    wy = s1.side[1] ? s1.far : s1.w - s1.far;
    prod = mgd_pkg::PROD_W'(wy) * mgd_pkg::PROD_W'(cur.fac[2]);
    s2_next      = s1;
    s2_next.w    = wy;
    s2_next.far  = prod[16 +: mgd_pkg::FAC_W];
    wz = s2.side[2] ? s2.far : s2.w - s2.far;
    s3_next       = s2;
    s3_next.valid = s2.valid && s2.keep;
    s3_next.w     = wz;
    s3_next.far   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mgd_pkg::ST_CLEAR;
      clr_cnt <= '0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      done    <= 1'b0;
      sat_acc <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mgd_pkg::ST_CLEAR) clr_cnt <= clr_cnt + mgd_pkg::ADDR_W'(1);
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      done <= res_valid;
      if (pop) sat_acc <= 1'b0;
      else if (sat_hit) sat_acc <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (pop) cnt <= '0;
    else if (state == mgd_pkg::ST_DEPOSIT) cnt <= cnt + mgd_pkg::CORNER_W'(1);
    bin_value <= res_value;
    skipped   <= res_skip;
    saturated <= res_sat;
  end

  always_comb begin
    logic [mgd_pkg::BIN_W:0] sum;
    state_next = state;
    pop        = 1'b0;
    res_valid  = 1'b0;
    res_value  = '0;
    res_skip   = 1'b0;
    res_sat    = 1'b0;
    we         = 1'b0;
    waddr      = s3.flat;
    wdata      = '0;
    re         = 1'b0;
    raddr      = s2.flat;
    sat_hit    = 1'b0;
    sum        = {1'b0, rdata} + (mgd_pkg::BIN_W + 1)'(s3.w);

    if (s2.valid && s2.keep) re = 1'b1;
    if (s3.valid) begin
      we = 1'b1;
      if (sum[mgd_pkg::BIN_W]) begin
        wdata   = '1;
        sat_hit = 1'b1;
      end else begin
        wdata = sum[mgd_pkg::BIN_W-1:0];
      end
    end

    unique case (state)
      mgd_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
        if (clr_cnt == mgd_pkg::ADDR_W'(mgd_pkg::HIST_DEPTH - 1)) state_next = mgd_pkg::ST_IDLE;
      end
      mgd_pkg::ST_IDLE: begin
        if (cmd_avail) begin
          pop = 1'b1;
          if (head.kind != mgd_pkg::CMD_DEPOSIT) begin
            state_next = mgd_pkg::ST_READ;
          end else if (head.skipped) begin
            res_valid = 1'b1;
            res_skip  = 1'b1;
          end else begin
            state_next = mgd_pkg::ST_DEPOSIT;
          end
        end
      end
      mgd_pkg::ST_READ: begin
        re         = 1'b1;
        raddr      = cur.addr;
        state_next = mgd_pkg::ST_READ_DATA;
      end
      mgd_pkg::ST_READ_DATA: begin
        res_valid = 1'b1;
        res_value = rdata;
        if (cur.kind == mgd_pkg::CMD_READ_ZERO) begin
          we    = 1'b1;
          waddr = cur.addr;
          wdata = '0;
        end
        state_next = mgd_pkg::ST_IDLE;
      end
      mgd_pkg::ST_DEPOSIT: begin
        if (cnt == '1) state_next = mgd_pkg::ST_DRAIN;
      end
      mgd_pkg::ST_DRAIN: begin
        if (!s1.valid && !s2.valid && !s3.valid) begin
          res_valid  = 1'b1;
          res_sat    = sat_acc;
          state_next = mgd_pkg::ST_IDLE;
        end
      end
      default: state_next = mgd_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/mgd_checker.sv
module mgd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic [mgd_pkg::BIN_W-1:0] bin_value,
  input logic                      skipped,
  input logic                      saturated
);

  // Reset starts the clearing sweep, so no item may be taken straight after.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result straight after reset");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    done && skipped |-> (bin_value == '0) && !saturated)
    else $error("skipped item carries other flags");

  a_sat_deposit: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (bin_value == '0))
    else $error("saturation reported on a read");

endmodule

bind multilinear_grid_deposit mgd_checker u_mgd_checker (.*);

// File: tb/multilinear_grid_deposit_test.sv
module multilinear_grid_deposit_test;

  localparam int WATCHDOG_LIMIT = 20000;

  // Clock and reset.
  logic clk;
  logic rst;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stimulus driven into the block.
  logic                          start;
  logic                          busy;
  logic [mgd_pkg::OP_W-1:0]      operation;
  logic [mgd_pkg::POS_W-1:0]     pos_x, pos_y, pos_z;
  logic [mgd_pkg::NEAR_W-1:0]    near_x, near_y, near_z;
  logic [mgd_pkg::FRAC_W-1:0]    frac_x, frac_y, frac_z;
  logic [mgd_pkg::ADDR_W-1:0]    bin_address;
  logic                          cfg_we;
  logic [mgd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mgd_pkg::LEN_W-1:0]     cfg_data;
  logic                          done;
  logic [mgd_pkg::BIN_W-1:0]     bin_value;
  logic                          skipped;
  logic                          saturated;

  multilinear_grid_deposit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .near_x(near_x), .near_y(near_y), .near_z(near_z),
    .frac_x(frac_x), .frac_y(frac_y), .frac_z(frac_z),
    .bin_address(bin_address), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .bin_value(bin_value),
    .skipped(skipped), .saturated(saturated)
  );

  // One input item and one result, at the port widths.
  typedef struct {
    logic [mgd_pkg::OP_W-1:0]   op;
    logic [mgd_pkg::POS_W-1:0]  pos [3];
    logic [mgd_pkg::NEAR_W-1:0] near [3];
    logic [mgd_pkg::FRAC_W-1:0] frac [3];
    logic [mgd_pkg::ADDR_W-1:0] addr;
  } grid_item_t;

  typedef struct {
    logic [mgd_pkg::BIN_W-1:0] value;
    logic                      skip;
    logic                      sat;
  } grid_result_t;

  // The testbench's own copy of the histogram and the length registers.
  logic [mgd_pkg::BIN_W-1:0] shadow_hist [mgd_pkg::HIST_DEPTH];
  logic [mgd_pkg::LEN_W-1:0] shadow_len [3];

  grid_result_t pending_results [$];
  int  failures;
  int  idle_cycles;
  bit  stim_done;

  // Directed rows: the item, and where it can be read off at a glance, the
  // result it must give.
  typedef struct {
    grid_item_t   item;
    bit           typed;
    grid_result_t result;
  } directed_row_t;

  directed_row_t directed_rows [$];

  function automatic logic [mgd_pkg::LEN_W-1:0] eff_len(input logic [mgd_pkg::LEN_W-1:0] v);
    if (v == '0) return mgd_pkg::LEN_W'(1);
    if (v > mgd_pkg::LEN_W'(mgd_pkg::MAX_BINS_PER_DIM))
      return mgd_pkg::LEN_W'(mgd_pkg::MAX_BINS_PER_DIM);
    return v;
  endfunction

  // Works out the result of one item and updates the shadow histogram.
  function automatic grid_result_t deposit_or_read(input grid_item_t it);
    grid_result_t r;
    int len [3];
    int nearest [3];
    int stepdir [3];
    bit split [3];
    longint fac [3];
    longint stride [3];
    int signed p;
    int signed fr;
    longint w;
    longint far_w;
    longint flat;
    longint sum;
    int coord;
    bit keep;
    bit side;
    r.value = '0;
    r.skip = 1'b0;
    r.sat = 1'b0;
    if (it.op != mgd_pkg::OPC_DEPOSIT) begin
      r.value = shadow_hist[it.addr];
      if (it.op == mgd_pkg::OPC_READ_ZERO) shadow_hist[it.addr] = '0;
      return r;
    end
    for (int d = 0; d < 3; d++) begin
      p  = int'($signed(it.pos[d]));
      fr = int'($signed(it.frac[d]));
      len[d] = int'(eff_len(shadow_len[d]));
      nearest[d] = int'(it.near[d]);
      if (p < 0 || p > (len[d] - 1) * 256) begin
        r.skip = 1'b1;
        return r;
      end
      split[d] = (fr != 0);
      stepdir[d] = (fr < 0) ? -1 : 1;
      fac[d] = longint'((fr < 0 ? -fr : fr) * 2);
    end
    stride[2] = 1;
    stride[1] = longint'(len[2]);
    stride[0] = longint'(len[1] * len[2]);
    for (int c = 0; c < 8; c++) begin
      w = 65536;
      flat = 0;
      keep = 1'b1;
      for (int d = 0; d < 3; d++) begin
        side = c[d];
        coord = nearest[d];
        if (side && !split[d]) begin
          keep = 1'b0;
          break;
        end
        if (split[d]) begin
          far_w = (w * fac[d]) >> 16;
          w = side ? far_w : w - far_w;
          if (side) coord += stepdir[d];
        end
        if (coord < 0 || coord >= len[d]) keep = 1'b0;
        else flat += longint'(coord) * stride[d];
      end
      if (keep && flat < mgd_pkg::HIST_DEPTH) begin
        sum = longint'(shadow_hist[flat]) + w;
        if (sum > 64'hFFFF_FFFF) begin
          sum = 64'hFFFF_FFFF;
          r.sat = 1'b1;
        end
        shadow_hist[flat] = sum[31:0];
      end
    end
    return r;
  endfunction

  // A random item, mostly deposits aimed mostly inside the grid, with random offsets of either sign.
  function automatic grid_item_t random_item();
    grid_item_t it;
    int l;
    it.op = mgd_pkg::OP_W'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 6) it.op = mgd_pkg::OPC_DEPOSIT;
    it.addr = mgd_pkg::ADDR_W'($urandom);
    for (int d = 0; d < 3; d++) begin
      l = int'(eff_len(shadow_len[d]));
      case ($urandom_range(0, 9))
        0:       it.pos[d] = mgd_pkg::POS_W'($urandom);
        1:       it.pos[d] = mgd_pkg::POS_W'((l - 1) * 256 + int'($urandom_range(0, 1)));
        default: it.pos[d] = mgd_pkg::POS_W'($urandom_range(0, (l - 1) * 256));
      endcase
      it.near[d] = ($urandom_range(0, 7) == 0) ? mgd_pkg::NEAR_W'($urandom) :
                                                 mgd_pkg::NEAR_W'($urandom_range(0, l - 1));
      case ($urandom_range(0, 7))
        0:       it.frac[d] = '0;
        1:       it.frac[d] = 16'h8000;
        2:       it.frac[d] = 16'h7FFF;
        default: it.frac[d] = mgd_pkg::FRAC_W'($urandom);
      endcase
    end
    // Reads aim mostly at the bins that deposits reach in small grids.
    if ($urandom_range(0, 1) == 0) it.addr = mgd_pkg::ADDR_W'($urandom_range(0, 63));
    return it;
  endfunction

  // Drives one item and waits for the edge at which it is accepted. start
  // stays high afterwards; the next item or a pause takes it over.
  task automatic send_item(input grid_item_t it);
    operation   <= it.op;
    pos_x       <= it.pos[0];
    pos_y       <= it.pos[1];
    pos_z       <= it.pos[2];
    near_x      <= it.near[0];
    near_y      <= it.near[1];
    near_z      <= it.near[2];
    frac_x      <= it.frac[0];
    frac_y      <= it.frac[1];
    frac_z      <= it.frac[2];
    bin_address <= it.addr;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender gaps: bursts of random length, then a random pause.
  int burst_left;

  task automatic maybe_pause();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    if ($urandom_range(0, 3) != 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A deposit has written all its corners before its result appears.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_len(input logic [mgd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mgd_pkg::LEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    shadow_len[idx] = v;
  endtask

  task automatic set_lengths(input logic [mgd_pkg::LEN_W-1:0] lx,
                             input logic [mgd_pkg::LEN_W-1:0] ly,
                             input logic [mgd_pkg::LEN_W-1:0] lz);
    drain_results();
    write_len(mgd_pkg::CFG_LEN_X, lx);
    write_len(mgd_pkg::CFG_LEN_Y, ly);
    write_len(mgd_pkg::CFG_LEN_Z, lz);
    cfg_we <= 1'b0;
  endtask

  task automatic push_row(input grid_item_t it, input bit typed,
                          input logic [mgd_pkg::BIN_W-1:0] v, input logic sk, input logic sa);
    directed_row_t row;
    row.item = it;
    row.typed = typed;
    row.result.value = v;
    row.result.skip = sk;
    row.result.sat = sa;
    directed_rows.push_back(row);
  endtask

  function automatic grid_item_t make_item(input logic [mgd_pkg::OP_W-1:0] op,
                                           input int px, input int py, input int pz,
                                           input int nx, input int ny, input int nz,
                                           input int fx, input int fy, input int fz,
                                           input int addr);
    grid_item_t it;
    it.op = op;
    it.pos[0] = mgd_pkg::POS_W'(px);
    it.pos[1] = mgd_pkg::POS_W'(py);
    it.pos[2] = mgd_pkg::POS_W'(pz);
    it.near[0] = mgd_pkg::NEAR_W'(nx);
    it.near[1] = mgd_pkg::NEAR_W'(ny);
    it.near[2] = mgd_pkg::NEAR_W'(nz);
    it.frac[0] = mgd_pkg::FRAC_W'(fx);
    it.frac[1] = mgd_pkg::FRAC_W'(fy);
    it.frac[2] = mgd_pkg::FRAC_W'(fz);
    it.addr = mgd_pkg::ADDR_W'(addr);
    return it;
  endfunction

  // Result checker: each strobe is matched against the oldest expectation.
  always @(posedge clk) begin
    grid_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: value %h skipped %b saturated %b",
                 $time, bin_value, skipped, saturated);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (bin_value !== exp_r.value) begin
          $display("%0t: bin_value expected %h actual %h", $time, exp_r.value, bin_value);
          failures++;
        end
        if (skipped !== exp_r.skip) begin
          $display("%0t: skipped expected %b actual %b", $time, exp_r.skip, skipped);
          failures++;
        end
        if (saturated !== exp_r.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, saturated);
          failures++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  // The clearing sweep after reset is well inside the limit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || stim_done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multilinear_grid_deposit verification failed");
      $finish;
    end
  end

  initial begin
    grid_item_t it;
    grid_result_t predicted;
    int sent;
    rst = 1'b1;
    start = 1'b0;
    operation = '0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    near_x = '0; near_y = '0; near_z = '0;
    frac_x = '0; frac_y = '0; frac_z = '0;
    bin_address = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failures = 0;
    stim_done = 1'b0;
    burst_left = 0;
    for (int i = 0; i < mgd_pkg::HIST_DEPTH; i++) shadow_hist[i] = '0;
    for (int d = 0; d < 3; d++) shadow_len[d] = mgd_pkg::LEN_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset lengths of sixteen bins per axis.
    // After reset every bin reads as zero, whichever read code is used.
    push_row(make_item(mgd_pkg::OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_READ_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4095), 1, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_SPARE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2048), 1, 0, 0, 0);
    // A point with no offset puts its whole unit weight on one bin.
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32'h10000, 0, 0);
    // Points off the grid on either side are skipped.
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 0, 3841, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 0, 0, 21'h0FFFFF, 0, 0, 0, 0, 0, 0, 0),
             1, 0, 1, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 0, 0, 21'h100000, 0, 0, 0, 0, 0, 0, 0),
             1, 0, 1, 0);
    // The top corner of the grid, full splits both ways at the extremes, then mixed splits and clearing reads.
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 3840, 3840, 3840, 15, 15, 15, 0, 0, 0, 0),
             0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 256, 256, 256, 1, 1, 1,
                       16'h8000, 16'h8000, 16'h8000, 0), 0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 3840, 3840, 3840, 15, 15, 15,
                       16'h7FFF, 16'h7FFF, 16'h7FFF, 0), 0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'h0001, 16'h4000, 0),
             0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_DEPOSIT, 512, 512, 512, 2, 3, 4,
                       16'h2000, 16'hC000, 16'h0000, 0), 0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_READ_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 273), 0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 273), 1, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_READ_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4095), 0, 0, 0, 0);
    push_row(make_item(mgd_pkg::OPC_READ_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      predicted = deposit_or_read(directed_rows[i].item);
      if (directed_rows[i].typed &&
          (predicted.value !== directed_rows[i].result.value ||
           predicted.skip !== directed_rows[i].result.skip ||
           predicted.sat !== directed_rows[i].result.sat)) begin
        $display("%0t: directed row %0d expected %h/%b/%b predicted %h/%b/%b", $time, i,
                 directed_rows[i].result.value, directed_rows[i].result.skip,
                 directed_rows[i].result.sat, predicted.value, predicted.skip, predicted.sat);
        failures++;
      end
      pending_results.push_back(predicted);
      send_item(directed_rows[i].item);
      maybe_pause();
    end

    // Repeated whole-weight deposits onto the single bin of a one-bin grid.
    // Reaching the saturation limit would take tens of thousands of them, so
    // the clipping path is left to the predictor's comparison of the flag.
    set_lengths(1, 1, 1);
    for (int k = 0; k < 4; k++) begin
      it = make_item(mgd_pkg::OPC_DEPOSIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      pending_results.push_back(deposit_or_read(it));
      send_item(it);
    end

    // Random part across several length settings, the extremes among them,
    // including the out-of-range codes zero and above sixteen.
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_lengths(16, 16, 16);
        1: set_lengths(2, 3, 4);
        2: set_lengths(0, 31, 1);
        3: set_lengths(17, 1, 0);
        4: set_lengths(1, 2, 1);
        5: set_lengths(5, 7, 3);
        6: set_lengths(mgd_pkg::LEN_W'($urandom_range(0, 31)),
                       mgd_pkg::LEN_W'($urandom_range(0, 31)),
                       mgd_pkg::LEN_W'($urandom_range(0, 31)));
        default: set_lengths(3, 3, 3);
      endcase
      for (int k = 0; k < 130; k++) begin
        it = random_item();
        pending_results.push_back(deposit_or_read(it));
        send_item(it);
        sent++;
        maybe_pause();
      end
    end

    drain_results();
    stim_done = 1'b1;
    if (failures == 0) begin
      $display("multilinear_grid_deposit verification clean");
    end else begin
      $display("multilinear_grid_deposit verification failed");
    end
    $finish;
  end

endmodule
